>>> src/u8u16_pkg.sv
package u8u16_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int ACC_W = 21;
  localparam int OFF_W = 20;

  localparam logic [5:0] HI_SURR_TAG = 6'b110110;
  localparam logic [5:0] LO_SURR_TAG = 6'b110111;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEAD = 3'd1,
    ST_BAD_CONT = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_OVERLONG = 3'd4,
    ST_RANGE    = 3'd5,
    ST_SURR     = 3'd6
  } status_t;

  // One queued job for the back end: a single unit, a surrogate pair
  // (payload is the value less 0x10000) or an error.
  typedef struct packed {
    logic             is_pair;
    logic [OFF_W-1:0] payload;
    status_t          status;
    logic             fin;
  } q_entry_t;

endpackage

>>> src/u8u16_front.sv
module u8u16_front import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       push,
  output q_entry_t   push_entry
);

  logic [1:0]       pend_r, pend_nxt;
  logic [1:0]       len_r, len_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             bad_r, bad_nxt;
  logic             drop_r, drop_nxt;

  logic             err;
  status_t          err_st;
  logic             ok_push;
  logic             ok_pair;
  logic [OFF_W-1:0] ok_payload;
  logic             lead_ok;
  logic [1:0]       trail;
  logic [ACC_W-1:0] lead_v;
  logic [ACC_W-1:0] acc_shift;
  logic [ACC_W-1:0] acc_off;
  logic             bad_cont;
  logic [1:0]       pend_dec;

  assign acc_shift = {acc_r[ACC_W-7:0], data_byte[5:0]};
  assign acc_off   = acc_shift - ACC_W'(24'h010000);
  assign bad_cont  = bad_r | (data_byte[7:6] != 2'b10);
  assign pend_dec  = pend_r - 2'd1;

  always_comb begin
    lead_ok = 1'b1;
    trail   = 2'd0;
    lead_v  = '0;
    if (data_byte inside {[8'hC2:8'hDF]}) begin
      trail  = 2'd1;
      lead_v = ACC_W'(data_byte[4:0]);
    end else if (data_byte inside {[8'hE0:8'hEF]}) begin
      trail  = 2'd2;
      lead_v = ACC_W'(data_byte[3:0]);
    end else if (data_byte inside {[8'hF0:8'hF4]}) begin
      trail  = 2'd3;
      lead_v = ACC_W'(data_byte[2:0]);
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    pend_nxt   = pend_r;
    len_nxt    = len_r;
    acc_nxt    = acc_r;
    bad_nxt    = bad_r;
    drop_nxt   = drop_r;
    err        = 1'b0;
    err_st     = ST_OK;
    ok_push    = 1'b0;
    ok_pair    = 1'b0;
    ok_payload = '0;

    if (accept) begin
      if (drop_r) begin
        if (final_byte) begin
          pend_nxt = '0;
          len_nxt  = '0;
          acc_nxt  = '0;
          bad_nxt  = 1'b0;
          drop_nxt = 1'b0;
        end
      end else if (pend_r == 2'd0) begin
        if (!data_byte[7]) begin
          ok_push    = 1'b1;
          ok_payload = OFF_W'(data_byte);
        end else if (!lead_ok) begin
          err    = 1'b1;
          err_st = ST_BAD_LEAD;
        end else if (final_byte) begin
          err    = 1'b1;
          err_st = ST_TRUNC;
        end else begin
          pend_nxt = trail;
          len_nxt  = trail;
          acc_nxt  = lead_v;
          bad_nxt  = 1'b0;
        end
      end else begin
        // continuation word
        if (pend_dec != 2'd0) begin
          if (final_byte) begin
            err    = 1'b1;
            err_st = ST_TRUNC;
          end else begin
            pend_nxt = pend_dec;
            acc_nxt  = acc_shift;
            bad_nxt  = bad_cont;
          end
        end else if (bad_cont) begin
          err    = 1'b1;
          err_st = ST_BAD_CONT;
        end else if ((len_r == 2'd1 && acc_shift < ACC_W'(12'h080)) ||
                     (len_r == 2'd2 && acc_shift < ACC_W'(12'h800)) ||
                     (len_r == 2'd3 && acc_shift < ACC_W'(24'h010000))) begin
          err    = 1'b1;
          err_st = ST_OVERLONG;
        end else if (acc_shift > ACC_W'(24'h10FFFF)) begin
          err    = 1'b1;
          err_st = ST_RANGE;
        end else if (acc_shift >= ACC_W'(16'hD800) &&
                     acc_shift <= ACC_W'(16'hDFFF)) begin
          err    = 1'b1;
          err_st = ST_SURR;
        end else begin
          pend_nxt = '0;
          len_nxt  = '0;
          acc_nxt  = '0;
          bad_nxt  = 1'b0;
          ok_push  = 1'b1;
          if (acc_shift[ACC_W-1:16] != '0) begin
            ok_pair    = 1'b1;
            ok_payload = acc_off[OFF_W-1:0];
          end else begin
            ok_payload = OFF_W'(acc_shift[15:0]);
          end
        end
      end

      if (err) begin
        pend_nxt = '0;
        len_nxt  = '0;
        acc_nxt  = '0;
        bad_nxt  = 1'b0;
        drop_nxt = !final_byte;
      end
    end
  end

  assign push               = err | ok_push;
  assign push_entry.is_pair = ok_pair;
  assign push_entry.payload = err ? '0 : ok_payload;
  assign push_entry.status  = err ? err_st : ST_OK;
  assign push_entry.fin     = final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      len_r  <= '0;
      acc_r  <= '0;
      bad_r  <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

>>> src/u8u16_queue.sv
module u8u16_queue import u8u16_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output logic     full,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push & !full;
  assign do_pop    = pop & not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> src/u8u16_back.sv
module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  q_entry_t    q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic [2:0]  out_status,
  output logic        out_run_last,
  output logic        out_string_done
);

  logic        valid_r, valid_nxt;
  logic        second_r, second_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        last_r, last_nxt;
  logic        done_r, done_nxt;
  logic        load;

  assign load = q_valid & (!valid_r | !out_stall);
  assign pop  = load & (!q_head.is_pair | second_r);

  always_comb begin
    valid_nxt  = valid_r & out_stall;
    second_nxt = second_r;
    unit_nxt   = unit_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    done_nxt   = done_r;
    if (load) begin
      valid_nxt  = 1'b1;
      status_nxt = q_head.status;
      if (q_head.is_pair && !second_r) begin
        // high half of the pair; entry stays queued for the low half
        second_nxt = 1'b1;
        unit_nxt   = {HI_SURR_TAG, q_head.payload[OFF_W-1:10]};
        last_nxt   = 1'b0;
        done_nxt   = 1'b0;
      end else if (q_head.is_pair) begin
        second_nxt = 1'b0;
        unit_nxt   = {LO_SURR_TAG, q_head.payload[9:0]};
        last_nxt   = 1'b1;
        done_nxt   = q_head.fin;
      end else begin
        second_nxt = 1'b0;
        unit_nxt   = q_head.payload[15:0];
        last_nxt   = 1'b1;
        done_nxt   = q_head.fin | (q_head.status != ST_OK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r   <= unit_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
    done_r   <= done_nxt;
  end

  assign out_valid       = valid_r;
  assign out_code_unit   = unit_r;
  assign out_status      = status_r;
  assign out_run_last    = last_r;
  assign out_string_done = done_r;

endmodule

>>> src/utf8_to_utf16_decoder_core.sv
// Validating UTF-8 to UTF-16 decoder. One byte word is taken per cycle unless
// in_stall is high; a byte that completes a scalar value gives one UTF-16
// word, or two (high then low surrogate) for values above 0xFFFF, and a
// malformed string gives one error word with a zero code unit, after which
// bytes are dropped up to the final byte. The front end decodes a byte in the
// cycle it is taken and posts a job into a four-entry queue; the back end
// turns a job into output words through an output register, one word per
// cycle unless out_stall is high, so a surrogate pair holds its job until its
// low half is loaded. Sustained input rate is one byte per cycle whatever
// the text when out_stall is low, as a pair needs a four-byte sequence;
// in_stall rises only when the queue is full.
module utf8_to_utf16_decoder_core import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic [2:0]  out_status,
  output logic        out_run_last,
  output logic        out_string_done
);

  logic     accept;
  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_head;
  logic     pop;

  assign in_stall = q_full;
  assign accept   = in_valid & !q_full;

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .final_byte (in_final_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  u8u16_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  u8u16_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_status      (out_status),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

`ifndef SYNTH
  // error words carry no code unit and always close the string
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_code_unit == '0 && out_run_last && out_string_done)
    else $error("error word malformed");

  // only the high half of a pair leaves run_last low
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |->
      out_code_unit[15:10] == HI_SURR_TAG && !out_string_done)
    else $error("run_last low on a word that is not a high surrogate");

  // a full queue means the back end is holding a word
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with nothing at the output");
`endif

endmodule

>>> bench/utf16_stream_checker.sv
module utf16_stream_checker import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_code_unit,
  input  logic [2:0]  out_status,
  input  logic        out_run_last,
  input  logic        out_string_done,
  output int          failures,
  output int          pending_words
);

  typedef struct {
    logic [15:0] unit;
    status_t     st;
    logic        last;
    logic        done;
  } utf16_word_t;

  utf16_word_t expected_words[$];

  // decoder state as the block should hold it
  logic [1:0]  cont_left;
  logic [1:0]  cont_total;
  logic [20:0] scalar_acc;
  logic        cont_bad;
  logic        skip_to_end;

  task automatic clear_seq();
    cont_left = 2'd0;
    cont_total = 2'd0;
    scalar_acc = '0;
    cont_bad = 1'b0;
  endtask

  task automatic post_word(input logic [15:0] unit, input status_t st, input logic last,
                           input logic done);
    utf16_word_t w;
    w.unit = unit;
    w.st = st;
    w.last = last;
    w.done = done;
    expected_words.insert(expected_words.size(), w);
  endtask

  // an error on the final byte leaves nothing to skip
  task automatic flag_error(input status_t st, input logic fin);
    clear_seq();
    skip_to_end = !fin;
    post_word(16'h0000, st, 1'b1, 1'b1);
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [1:0]  trail;
    logic [20:0] v;
    logic [19:0] off;
    if (skip_to_end) begin
      if (fin) begin
        clear_seq();
        skip_to_end = 1'b0;
      end
      return;
    end

    if (cont_left == 2'd0) begin
      if (b <= 8'h7F) begin
        post_word({8'h00, b}, ST_OK, 1'b1, fin);
        return;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        trail = 2'd1;
        v = {16'b0, b[4:0]};
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        trail = 2'd2;
        v = {17'b0, b[3:0]};
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        trail = 2'd3;
        v = {18'b0, b[2:0]};
      end else begin
        flag_error(ST_BAD_LEAD, fin);
        return;
      end
      if (fin) begin
        flag_error(ST_TRUNC, fin);
        return;
      end
      cont_left = trail;
      cont_total = trail;
      scalar_acc = v;
      cont_bad = 1'b0;
      return;
    end

    if (b[7:6] != 2'b10) cont_bad = 1'b1;
    scalar_acc = {scalar_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;

    // truncation wins over a bad continuation
    if (cont_left != 2'd0) begin
      if (fin) flag_error(ST_TRUNC, fin);
      return;
    end
    if (cont_bad) begin
      flag_error(ST_BAD_CONT, fin);
      return;
    end

    v = scalar_acc;
    if ((cont_total == 2'd1 && v < 21'h80) || (cont_total == 2'd2 && v < 21'h800) ||
        (cont_total == 2'd3 && v < 21'h10000)) begin
      flag_error(ST_OVERLONG, fin);
      return;
    end
    if (v > 21'h10FFFF) begin
      flag_error(ST_RANGE, fin);
      return;
    end
    if (v >= 21'hD800 && v <= 21'hDFFF) begin
      flag_error(ST_SURR, fin);
      return;
    end

    clear_seq();
    if (v <= 21'hFFFF) begin
      post_word(v[15:0], ST_OK, 1'b1, fin);
    end else begin
      off = v[19:0] - 20'h10000;
      post_word({HI_SURR_TAG, off[19:10]}, ST_OK, 1'b0, 1'b0);
      post_word({LO_SURR_TAG, off[9:0]}, ST_OK, 1'b1, fin);
    end
  endtask

  always @(posedge clk) begin : watch
    utf16_word_t want;
    if (!rst_n) begin
      clear_seq();
      skip_to_end = 1'b0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: code unit %h, status %0d", out_code_unit, out_status);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (out_code_unit !== want.unit) begin
            $error("code_unit: expected %h, actual %h", want.unit, out_code_unit);
            failures++;
          end
          if (out_status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, out_status);
            failures++;
          end
          if (out_run_last !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, out_run_last);
            failures++;
          end
          if (out_string_done !== want.done) begin
            $error("string_done: expected %b, actual %b", want.done, out_string_done);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) decode_byte(in_data_byte, in_final_byte);
    end
    pending_words = expected_words.size();
  end

endmodule

>>> bench/tb_top.sv
module tb_top;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code_unit;
  logic [2:0]  out_status;
  logic        out_run_last;
  logic        out_string_done;

  int check_failures;
  int pending_words;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;

  utf8_to_utf16_decoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_final_byte(in_final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_unit(out_code_unit), .out_status(out_status),
    .out_run_last(out_run_last), .out_string_done(out_string_done)
  );

  utf16_stream_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_final_byte(in_final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_code_unit(out_code_unit), .out_status(out_status),
    .out_run_last(out_run_last), .out_string_done(out_string_done),
    .failures(check_failures), .pending_words(pending_words)
  );

  always #4 clk = ~clk;

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

  // stall is sampled mid-cycle, where it is settled
  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic held;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_byte <= fin;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    bytes_sent++;
  endtask

  task automatic send_text(input byte_q_t txt);
    int i;
    for (i = 0; i < txt.size(); i++) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    @(posedge clk);
  endtask

  // encodes in the given length whether or not that form is legal
  function automatic byte_q_t utf8_bytes(input logic [20:0] cp, input int len);
    byte_q_t q;
    case (len)
      1: q = '{{1'b0, cp[6:0]}};
      2: q = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
      3: q = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      default: q = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
                     {2'b10, cp[5:0]}};
    endcase
    return q;
  endfunction

  task automatic pick_scalar(output logic [20:0] cp, output int len);
    case ($urandom_range(3))
      0: begin
        len = 1;
        cp = 21'($urandom_range(8'h7F, 0));
      end
      1: begin
        len = 2;
        cp = 21'($urandom_range(16'h7FF, 16'h80));
      end
      2: begin
        len = 3;
        cp = 21'($urandom_range(16'hF7FF, 16'h800));
        if (cp >= 21'hD800) cp = cp + 21'h800;
      end
      default: begin
        len = 4;
        cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
      end
    endcase
  endtask

  task automatic send_random_string();
    byte_q_t txt, piece;
    logic [20:0] cp;
    int len, n, kind, k, i;
    logic [1:0] top2;
    txt = '{};
    n = $urandom_range(6, 1);
    for (i = 0; i < n; i++) begin
      pick_scalar(cp, len);
      kind = $urandom_range(99);
      if (kind < 80) begin
        piece = utf8_bytes(cp, len);
      end else if (kind < 84) begin
        piece = '{8'($urandom_range(255))};
      end else if (kind < 88) begin
        len = $urandom_range(4, 2);
        cp = (len == 2) ? 21'($urandom_range(8'h7F)) :
             (len == 3) ? 21'($urandom_range(16'h7FF)) : 21'($urandom_range(16'hFFFF));
        piece = utf8_bytes(cp, len);
      end else if (kind < 91) begin
        piece = utf8_bytes(21'($urandom_range(16'hDFFF, 16'hD800)), 3);
      end else if (kind < 94) begin
        cp = $urandom_range(1) ? 21'($urandom_range(21'h13FFFF, 21'h110000)) :
                                 21'($urandom_range(21'h1FFFFF, 21'h110000));
        piece = utf8_bytes(cp, 4);
      end else begin
        // continuation byte without the 10 prefix
        if (len < 2) begin
          len = 2;
          cp = 21'($urandom_range(16'h7FF, 16'h80));
        end
        piece = utf8_bytes(cp, len);
        k = $urandom_range(len - 1, 1);
        top2 = 2'($urandom_range(2));
        if (top2 == 2'b10) top2 = 2'b11;
        piece[k] = {top2, 6'($urandom_range(63))};
      end
      txt = {txt, piece};
    end
    // sometimes cut the string short inside a sequence
    if ($urandom_range(9) == 0) begin
      pick_scalar(cp, len);
      if (len == 1) len = 4;
      piece = utf8_bytes(21'($urandom_range(21'h10FFFF, 21'h10000)), len);
      k = $urandom_range(len - 1, 1);
      for (i = 0; i < k; i++) txt.insert(txt.size(), piece[i]);
    end
    send_text(txt);
  endtask

  initial begin : stimulus
    int phase, target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text('{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F});
    send_text('{8'hFF});
    send_text('{8'h80, 8'h41});
    send_text('{8'hE0, 8'h80, 8'h80});
    send_text('{8'hF4, 8'h90, 8'h80, 8'h80});
    send_text('{8'hED, 8'hA0, 8'h80});
    send_text('{8'hC2, 8'h41});
    send_text('{8'hE1, 8'h41});
    send_text('{8'hE0});
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      target = bytes_sent + 180;
      while (bytes_sent < target) send_random_string();
      drain();
    end

    repeat (16) @(negedge clk);
    if (check_failures == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

>>> utf8_to_utf16_decoder_core.f
src/u8u16_pkg.sv
src/u8u16_front.sv
src/u8u16_queue.sv
src/u8u16_back.sv
src/utf8_to_utf16_decoder_core.sv
bench/utf16_stream_checker.sv
bench/tb_top.sv
